// File: rtl/core/vn_pkg.sv
// Shared constants and request/result types for the 4D vector normalise unit.
package vn_pkg;

    localparam int CB       = 16;               // component width, Q8.8
    localparam int UF       = 14;               // unit fraction bits
    localparam int LEN_W    = CB + 1;           // magnitude width
    localparam int SQ_W     = 2 * CB - 1;       // one square
    localparam int SUM_W    = 2 * CB + 1;       // sum of four squares
    localparam int RT_STEPS = (SUM_W + 1) / 2;  // root digits
    localparam int RAD_W    = 2 * RT_STEPS;     // padded radicand
    localparam int REM_W    = LEN_W + 3;        // root remainder
    localparam int Q_W      = UF + 1;           // unit quotient magnitude
    localparam int UNIT_W   = UF + 2;           // signed unit component
    localparam int NUM_W    = CB + UF;          // dividend width

    typedef struct packed {
        logic signed [CB-1:0] comp_x;
        logic signed [CB-1:0] comp_y;
        logic signed [CB-1:0] comp_z;
        logic signed [CB-1:0] comp_w;
    } t_in_req;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic signed [UNIT_W-1:0] unit_w;
        logic [LEN_W-1:0]         length;
        logic                     zero_vector;
    } t_out_res;

endpackage

// File: rtl/core/vector4_normalize_unit.sv
// Throughput: one request per cycle unless the output stalls.
// Stages: 2 input, 1 sum, 17 root-digit, 16 divide, 1 output.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits and holds o_ready low;
// payload registers are not reset.
// Top level: handshake around the normalise pipeline.
module vector4_normalize_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  vn_pkg::t_in_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output vn_pkg::t_out_res o_res
);
    logic w_en;

    // Advance whenever the output register is empty or being drained
    assign w_en    = !o_valid || i_ready;
    // Refuse requests while reset is held
    assign o_ready = w_en && i_rst_n;

    vn_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

// File: rtl/core/vn_pipe.sv
// Pipelined datapath: squares, sum, digit-by-digit root, four restoring dividers.
module vn_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vn_pkg::t_in_req  i_req,
    output logic             o_valid,
    output vn_pkg::t_out_res o_res
);
    localparam int CB    = vn_pkg::CB;
    localparam int RT    = vn_pkg::RT_STEPS;
    localparam int QW    = vn_pkg::Q_W;
    localparam int DV0   = 3 + RT;       // stage of first divider entry
    localparam int L     = DV0 + QW + 1; // stages before the output register

    logic             r_vld [L];
    logic [CB-1:0]    r_cm  [L][4];
    logic             r_cn  [L][4];
    logic [vn_pkg::SQ_W-1:0]  r_sq [4];
    logic [vn_pkg::RAD_W-1:0] r_rad  [RT+1];
    logic [vn_pkg::REM_W-1:0] r_rem  [RT+1];
    logic [vn_pkg::LEN_W-1:0] r_root [RT+1];
    logic [vn_pkg::LEN_W-1:0] r_len  [QW+1];
    logic [vn_pkg::LEN_W-1:0] r_drem [QW+1][4];
    logic [QW-1:0]            r_q    [QW+1][4];
    logic                     r_ovld;
    vn_pkg::t_out_res         r_res;

    logic [CB-1:0] n_raw [4];
    assign n_raw[0] = i_req.comp_x;
    assign n_raw[1] = i_req.comp_y;
    assign n_raw[2] = i_req.comp_z;
    assign n_raw[3] = i_req.comp_w;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) r_vld[i] <= 1'b0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < L; i++) r_vld[i] <= r_vld[i-1];
            r_ovld <= r_vld[L-1];
        end
    end

    // Take magnitudes and signs, then carry them down the line
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_cn[0][c] <= n_raw[c][CB-1];
                r_cm[0][c] <= n_raw[c][CB-1] ? (CB'(0) - n_raw[c]) : n_raw[c];
            end
            for (int i = 1; i < L; i++) begin
                for (int c = 0; c < 4; c++) begin
                    r_cm[i][c] <= r_cm[i-1][c];
                    r_cn[i][c] <= r_cn[i-1][c];
                end
            end
        end
    end

    // Square each magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_sq[c] <= vn_pkg::SQ_W'((2*CB)'(r_cm[0][c]) * (2*CB)'(r_cm[0][c]));
            end
        end
    end

    // Sum the squares into the root radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= vn_pkg::RAD_W'(vn_pkg::SUM_W'(r_sq[0]) + vn_pkg::SUM_W'(r_sq[1])
                                      + vn_pkg::SUM_W'(r_sq[2]) + vn_pkg::SUM_W'(r_sq[3]));
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // One root digit per stage
    for (genvar j = 0; j < RT; j++) begin : g_root
        logic [vn_pkg::REM_W-1:0] n_sh;
        logic [vn_pkg::REM_W-1:0] n_trial;
        logic                     n_ge;
        assign n_sh    = vn_pkg::REM_W'({r_rem[j], r_rad[j][vn_pkg::RAD_W-1 -: 2]});
        assign n_trial = vn_pkg::REM_W'({r_root[j], 2'b01});
        assign n_ge    = (n_sh >= n_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j+1]  <= {r_rad[j][vn_pkg::RAD_W-3:0], 2'b00};
                r_rem[j+1]  <= n_ge ? (n_sh - n_trial) : n_sh;
                r_root[j+1] <= {r_root[j][vn_pkg::LEN_W-2:0], n_ge};
            end
        end
    end

    // Load the dividers: partial remainder is the dividend's top bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= r_root[RT];
            for (int c = 0; c < 4; c++) begin
                r_drem[0][c] <= vn_pkg::LEN_W'({r_cm[DV0-1][c], {vn_pkg::UF{1'b0}}} >> QW);
                r_q[0][c]    <= '0;
            end
        end
    end

    // One quotient bit per stage for each component
    for (genvar k = 0; k < QW; k++) begin : g_div
        for (genvar c = 0; c < 4; c++) begin : g_lane
            logic                       n_bit;
            logic [vn_pkg::LEN_W:0]     n_sh;
            logic                       n_ge;
            if (QW - 1 - k >= vn_pkg::UF) begin : g_mbit
                assign n_bit = r_cm[DV0+k][c][QW-1-k-vn_pkg::UF];
            end else begin : g_zbit
                assign n_bit = 1'b0;
            end
            assign n_sh = {r_drem[k][c], n_bit};
            assign n_ge = (n_sh >= {1'b0, r_len[k]});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_drem[k+1][c] <= vn_pkg::LEN_W'(n_ge ? (n_sh - {1'b0, r_len[k]}) : n_sh);
                    r_q[k+1][c]    <= {r_q[k][c][QW-2:0], n_ge};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_len[k+1] <= r_len[k];
        end
    end

    // Apply signs, force zeros for a zero vector, hold the result
    logic [vn_pkg::UNIT_W-1:0] n_unit [4];
    logic                      n_zero;
    assign n_zero = (r_len[QW] == '0);
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (n_zero) n_unit[c] = '0;
            else if (r_cn[L-1][c]) n_unit[c] = vn_pkg::UNIT_W'(0) - vn_pkg::UNIT_W'(r_q[QW][c]);
            else n_unit[c] = vn_pkg::UNIT_W'(r_q[QW][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.unit_x      <= n_unit[0];
            r_res.unit_y      <= n_unit[1];
            r_res.unit_z      <= n_unit[2];
            r_res.unit_w      <= n_unit[3];
            r_res.length      <= r_len[QW];
            r_res.zero_vector <= n_zero;
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_res;

endmodule

// File: rtl/core/vn_checker.sv
// Port-level checker for the normalise unit, bound to the top level.
module vn_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input vn_pkg::t_out_res o_res
);
    // Flag and zero length agree
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.zero_vector == (o_res.length == '0)))
        else $error("zero flag disagrees with length");

    // Zero vector gives zero units
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.zero_vector) |-> (o_res.unit_x == '0 && o_res.unit_y == '0
                                           && o_res.unit_z == '0 && o_res.unit_w == '0))
        else $error("zero vector with non-zero units");

    // Length never exceeds full scale
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.length[vn_pkg::LEN_W-1]) |-> (o_res.length[vn_pkg::LEN_W-2:0] == '0))
        else $error("length above full scale");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_res)))
        else $error("stalled result changed");

endmodule

bind vector4_normalize_unit vn_checker u_vn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_res   (o_res)
);

// File: dv/vector4_normalize_unit_tb.sv
// Self-checking testbench for the 4D vector normalise unit.
`timescale 1ns / 1ps

module vector4_normalize_unit_tb;

    localparam int RANDOM_REQS = 1550;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    vn_pkg::t_in_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    vn_pkg::t_out_res o_res;

    vn_pkg::t_in_req pending_reqs[$];
    vn_pkg::t_out_res expected_units[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 84;
    int hold_off_left = 0;

    vector4_normalize_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

    always #4 i_clk = ~i_clk;

    // Floor square root, digit by digit.
    function automatic logic [vn_pkg::LEN_W-1:0] floor_root(
        logic [vn_pkg::SUM_W-1:0] radicand);
        logic [35:0] rem;
        logic [35:0] root;
        logic [35:0] bitv;
        rem = 36'(radicand);
        root = '0;
        bitv = 36'd1 << 34;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root[vn_pkg::LEN_W-1:0];
    endfunction

    // Work out the unit vector and magnitude of one request.
    function automatic vn_pkg::t_out_res normalise_vector(vn_pkg::t_in_req req);
        logic signed [vn_pkg::CB-1:0] comps[4];
        logic [vn_pkg::CB:0] mags[4];
        logic [vn_pkg::SUM_W-1:0] sum_sq;
        logic [vn_pkg::LEN_W-1:0] len;
        logic [vn_pkg::NUM_W:0] quot;
        logic signed [vn_pkg::UNIT_W-1:0] units[4];
        vn_pkg::t_out_res res;
        comps = '{req.comp_x, req.comp_y, req.comp_z, req.comp_w};
        sum_sq = '0;
        for (int i = 0; i < 4; i++) begin
            mags[i] = comps[i] < 0 ? -$signed({comps[i][vn_pkg::CB-1], comps[i]})
                                   : {1'b0, comps[i]};
            sum_sq += mags[i] * mags[i];
        end
        len = floor_root(sum_sq);
        for (int i = 0; i < 4; i++) begin
            quot = (len == 0) ? '0 : ({mags[i], {vn_pkg::UF{1'b0}}} / len);
            units[i] = comps[i] < 0 ? -quot[vn_pkg::UNIT_W-1:0] : quot[vn_pkg::UNIT_W-1:0];
        end
        res.unit_x = units[0];
        res.unit_y = units[1];
        res.unit_z = units[2];
        res.unit_w = units[3];
        res.length = len;
        res.zero_vector = (len == 0);
        return res;
    endfunction

    function automatic logic [vn_pkg::CB-1:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive requests, advancing only on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_req <= pending_reqs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        if (i_valid && o_ready && i_rst_n)
            expected_units.push_back(normalise_vector(i_req));
    end

    // Accept results, check them and toggle receiver readiness.
    always @(posedge i_clk) begin
        if (o_valid && i_ready && i_rst_n) begin
            if (expected_units.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %p", o_res);
            end else if (o_res !== expected_units[0]) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected %p actual %p", expected_units[0], o_res);
                void'(expected_units.pop_front());
            end else begin
                void'(expected_units.pop_front());
            end
        end
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    // Watchdog on handshake inactivity.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("vector4_normalize_unit test failed");
            $finish;
        end
    end

    initial begin
        vn_pkg::t_in_req req;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: zero vector, full scale, single axes, mixed signs.
        pending_reqs.push_back('0);
        pending_reqs.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
        pending_reqs.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        pending_reqs.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        pending_reqs.push_back('{16'h0001, 16'h0000, 16'h0000, 16'h0000});
        pending_reqs.push_back('{16'h0000, 16'hffff, 16'h0000, 16'h0000});
        pending_reqs.push_back('{16'h0000, 16'h0000, 16'h8000, 16'h0000});
        pending_reqs.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h7fff});
        pending_reqs.push_back('{16'h0100, 16'hff00, 16'h0100, 16'hff00});
        pending_reqs.push_back('{16'h0003, 16'h0004, 16'h0000, 16'h0000});
        pending_reqs.push_back('{16'h5555, 16'haaaa, 16'h00ff, 16'hff01});
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 24 : 0;
            for (int n = 0; n < RANDOM_REQS / 3; n++) begin
                req.comp_x = random_comp();
                req.comp_y = random_comp();
                req.comp_z = random_comp();
                req.comp_w = random_comp();
                pending_reqs.push_back(req);
            end
            // Long receiver stall with the sender still offering requests.
            if (phase == 2) begin
                @(posedge i_clk);
                hold_off_left <= 300;
            end
            while (pending_reqs.size() > 0 || i_valid) @(posedge i_clk);
        end
        while (expected_units.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && expected_units.size() == 0) begin
            $display("vector4_normalize_unit test passed");
        end else begin
            $display("vector4_normalize_unit test failed");
        end
        $finish;
    end
endmodule

// File: vector4_normalize_unit.f
rtl/core/vn_pkg.sv
rtl/core/vn_pipe.sv
rtl/core/vector4_normalize_unit.sv
rtl/core/vn_checker.sv
dv/vector4_normalize_unit_tb.sv
